[rtl/core/wvrp_pkg.sv]
// Shared constants, types and helper functions of the vertex rotate and project core.
package wvrp_pkg;

  // Angle and coordinate formats.
  localparam int ANGLE_BITS      = 16;
  localparam int COORD_FRAC_BITS = 4;
  localparam logic [31:0] ANGLE_MASK = 32'((64'd1 << ANGLE_BITS) - 64'd1);

  // Sine and cosine are Q2.14.
  localparam int UNIT_FRAC = 14;
  localparam int SC_W      = UNIT_FRAC + 2;
  localparam int UNIT_ONE  = 1 << UNIT_FRAC;

  // Rotation unit.
  localparam int CORDIC_STEPS = 30;
  localparam int CX_W         = 34;
  localparam int CZ_W         = 33;
  localparam int CORDIC_DROP  = 16;
  localparam int CORDIC_LAT   = CORDIC_STEPS + 2;
  localparam logic [31:0] CORDIC_GAIN = 32'd652032874;
  localparam logic [31:0] ATAN_TURN [0:CORDIC_STEPS-1] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001};

  // Coordinate widths through the rotations.
  localparam int PT_W = 16;
  localparam int ZW   = 20;
  localparam int CW   = 21;

  // Thickness scaling: divide by 100 through a reciprocal multiply.
  localparam int TP_W          = 10;
  localparam logic [TP_W-1:0] THICK_RESET = TP_W'(100);
  localparam int TH_PROD_W     = PT_W + TP_W + 1;
  localparam int TH_MAG_W      = 26;
  localparam int TH_SHIFT      = 32;
  localparam logic [25:0] THICK_RECIP = 26'd42949673;
  localparam int TH_Q_W        = TH_MAG_W + 26;

  // Perspective and division.
  localparam int SIZE_W     = 16;
  localparam int CTR_W      = 32;
  localparam int PERSP_BASE = 625;
  localparam int DEPTH_MIN_SHIFT = 6;
  localparam int TW      = CW + SIZE_W + 1;
  localparam int MW      = 24 + COORD_FRAC_BITS;
  localparam int DW      = ((TW > MW + 1) ? TW : MW + 1) + 1;
  localparam int DEN_W   = DW - 1;
  localparam int SCALE_W = 11 + COORD_FRAC_BITS;
  localparam int PW      = TW + SCALE_W;
  localparam int NW      = ((PW - 1 > DEN_W) ? PW - 1 : DEN_W) + 1;
  localparam int QW      = 30;
  localparam int SUM_W   = CTR_W + 2;
  localparam logic signed [DW-1:0] PERSP_M =
    DW'(PERSP_BASE) << (UNIT_FRAC + COORD_FRAC_BITS);
  localparam logic signed [DW-1:0] PERSP_DMIN = PERSP_M >>> DEPTH_MIN_SHIFT;
  localparam logic signed [SCALE_W-1:0] PERSP_SCALE =
    SCALE_W'(PERSP_BASE) << COORD_FRAC_BITS;

  // Register map.
  localparam int ADDR_W = 3;
  localparam logic REG_THICKNESS = 1'b0;

  // Item traveling beside the sine and cosine units.
  typedef struct packed {
    logic                     v;
    logic signed [PT_W-1:0]   x;
    logic signed [PT_W-1:0]   y;
    logic signed [ZW-1:0]     z;
    logic                     prism;
    logic [SIZE_W-1:0]        size;
    logic signed [CTR_W-1:0]  cx;
    logic signed [CTR_W-1:0]  cy;
  } side_t;

  // Item traveling beside the rotation stages.
  typedef struct packed {
    logic                     v;
    logic signed [CW-1:0]     u;
    logic [SIZE_W-1:0]        size;
    logic signed [CTR_W-1:0]  cx;
    logic signed [CTR_W-1:0]  cy;
    logic signed [SC_W-1:0]   s1;
    logic signed [SC_W-1:0]   c1;
    logic signed [SC_W-1:0]   s2;
    logic signed [SC_W-1:0]   c2;
  } hold_t;

  function automatic logic signed [SC_W-1:0] clamp_unit(input logic signed [CX_W:0] v);
    logic signed [SC_W-1:0] r;
    if (v > (CX_W+1)'(UNIT_ONE)) r = SC_W'(UNIT_ONE);
    else if (v < -(CX_W+1)'(UNIT_ONE)) r = -SC_W'(UNIT_ONE);
    else r = SC_W'(v);
    return r;
  endfunction

  function automatic logic signed [CTR_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
    logic signed [CTR_W-1:0] r;
    if (v[SUM_W-1:CTR_W-1] == '0 || v[SUM_W-1:CTR_W-1] == '1) r = CTR_W'(v);
    else if (v[SUM_W-1]) r = {1'b1, {(CTR_W-1){1'b0}}};
    else r = {1'b0, {(CTR_W-1){1'b1}}};
    return r;
  endfunction

endpackage

[rtl/core/wvrp_cordic.sv]
// Pipelined CORDIC that turns one angle into Q2.14 sine and cosine.
module wvrp_cordic import wvrp_pkg::*; (
  input  logic                   clk,
  input  logic [15:0]            angle,
  output logic signed [SC_W-1:0] sin_val,
  output logic signed [SC_W-1:0] cos_val
);

  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;
  localparam logic [1:0] QUAD_3 = 2'd3;
  localparam logic signed [CX_W:0] CORDIC_RND = (CX_W+1)'(1) << (CORDIC_DROP - 1);

  logic [31:0]            phase;
  logic signed [CX_W-1:0] xs [0:CORDIC_STEPS];
  logic signed [CX_W-1:0] ys [0:CORDIC_STEPS];
  logic signed [CZ_W-1:0] zs [0:CORDIC_STEPS];
  logic [1:0]             quad [0:CORDIC_STEPS];
  logic signed [CX_W:0]   xr;
  logic signed [CX_W:0]   yr;
  logic signed [SC_W-1:0] cq;
  logic signed [SC_W-1:0] sq;

  assign phase = (32'(angle) & ANGLE_MASK) << (32 - ANGLE_BITS);

  // The quadrant is split off; the loop only sees the first quarter turn.
  always_ff @(posedge clk) begin
    xs[0]   <= CX_W'(CORDIC_GAIN);
    ys[0]   <= '0;
    zs[0]   <= CZ_W'(phase[29:0]);
    quad[0] <= phase[31:30];
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    logic signed [CZ_W-1:0] atan_i;
    assign atan_i = $signed(CZ_W'(ATAN_TURN[i]));
    always_ff @(posedge clk) begin
      if (!zs[i][CZ_W-1]) begin
        xs[i+1] <= xs[i] - (ys[i] >>> i);
        ys[i+1] <= ys[i] + (xs[i] >>> i);
        zs[i+1] <= zs[i] - atan_i;
      end else begin
        xs[i+1] <= xs[i] + (ys[i] >>> i);
        ys[i+1] <= ys[i] - (xs[i] >>> i);
        zs[i+1] <= zs[i] + atan_i;
      end
      quad[i+1] <= quad[i];
    end
  end

  assign xr = (CX_W+1)'(xs[CORDIC_STEPS]) + CORDIC_RND;
  assign yr = (CX_W+1)'(ys[CORDIC_STEPS]) + CORDIC_RND;
  assign cq = clamp_unit(xr >>> CORDIC_DROP);
  assign sq = clamp_unit(yr >>> CORDIC_DROP);

  always_ff @(posedge clk) begin
    unique case (quad[CORDIC_STEPS])
      QUAD_0: begin cos_val <= cq;  sin_val <= sq;  end
      QUAD_1: begin cos_val <= -sq; sin_val <= cq;  end
      QUAD_2: begin cos_val <= -cq; sin_val <= -sq; end
      QUAD_3: begin cos_val <= sq;  sin_val <= -cq; end
      default: begin cos_val <= cq; sin_val <= sq;  end
    endcase
  end

endmodule

[rtl/core/wvrp_rot.sv]
// Two-stage planar rotation: out1 = a*c - b*s, out2 = a*s + b*c, rounded to Q14.
module wvrp_rot import wvrp_pkg::*; (
  input  logic                   clk,
  input  logic signed [CW-1:0]   a,
  input  logic signed [CW-1:0]   b,
  input  logic signed [SC_W-1:0] c,
  input  logic signed [SC_W-1:0] s,
  output logic signed [CW-1:0]   out1,
  output logic signed [CW-1:0]   out2
);

  localparam int PRW = CW + SC_W;
  localparam logic signed [PRW:0] RND = (PRW+1)'(1) << (UNIT_FRAC - 1);

  logic signed [PRW-1:0] p_ac, p_bs, p_as, p_bc;
  logic signed [PRW:0]   sum1, sum2;

  always_ff @(posedge clk) begin
    p_ac <= a * c;
    p_bs <= b * s;
    p_as <= a * s;
    p_bc <= b * c;
  end

  assign sum1 = (PRW+1)'(p_ac) - (PRW+1)'(p_bs) + RND;
  assign sum2 = (PRW+1)'(p_as) + (PRW+1)'(p_bc) + RND;

  always_ff @(posedge clk) begin
    out1 <= CW'(sum1 >>> UNIT_FRAC);
    out2 <= CW'(sum2 >>> UNIT_FRAC);
  end

endmodule

[rtl/core/wvrp_div.sv]
// Pipelined restoring divider, one quotient bit per stage.
module wvrp_div import wvrp_pkg::*; (
  input  logic             clk,
  input  logic [NW-1:0]    num,
  input  logic [DEN_W-1:0] den,
  output logic [QW-1:0]    quot
);

  logic [DEN_W-1:0] rem_q  [0:QW-1];
  logic [DEN_W-1:0] den_q  [0:QW-1];
  logic [QW-1:0]    low_q  [0:QW-1];
  logic [QW-1:0]    quot_q [0:QW-1];

  for (genvar i = 0; i < QW; i++) begin : g_bit
    logic [DEN_W-1:0] r_in;
    logic [DEN_W-1:0] d_in;
    logic [QW-1:0]    l_in;
    logic [QW-1:0]    q_in;
    logic [DEN_W:0]   trial;

    if (i == 0) begin : g_first
      // The quotient fits in QW bits, so the upper numerator bits are below den.
      assign r_in = DEN_W'(num >> QW);
      assign d_in = den;
      assign l_in = num[QW-1:0];
      assign q_in = '0;
    end else begin : g_next
      assign r_in = rem_q[i-1];
      assign d_in = den_q[i-1];
      assign l_in = low_q[i-1];
      assign q_in = quot_q[i-1];
    end

    assign trial = {r_in, l_in[QW-1]};

    always_ff @(posedge clk) begin
      if (trial >= {1'b0, d_in}) begin
        rem_q[i]  <= DEN_W'(trial - {1'b0, d_in});
        quot_q[i] <= {q_in[QW-2:0], 1'b1};
      end else begin
        rem_q[i]  <= DEN_W'(trial);
        quot_q[i] <= {q_in[QW-2:0], 1'b0};
      end
      den_q[i] <= d_in;
      low_q[i] <= l_in << 1;
    end
  end

  assign quot = quot_q[QW-1];

endmodule

[rtl/core/wvrp_proj.sv]
// Weak perspective: scale by size over the depth term, divide, round, offset and saturate.
module wvrp_proj import wvrp_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  input  logic signed [CW-1:0]    x3,
  input  logic signed [CW-1:0]    y3,
  input  logic signed [CW-1:0]    z2,
  input  logic [SIZE_W-1:0]       size,
  input  logic signed [CTR_W-1:0] cx,
  input  logic signed [CTR_W-1:0] cy,
  output logic                    done,
  output logic signed [CTR_W-1:0] screen_x,
  output logic signed [CTR_W-1:0] screen_y,
  output logic                    depth_clamped
);

  typedef struct packed {
    logic                    v;
    logic                    neg_x;
    logic                    neg_y;
    logic                    clamped;
    logic signed [CTR_W-1:0] cx;
    logic signed [CTR_W-1:0] cy;
  } pside_t;

  // Stage 1: products with size.
  logic                    v1;
  logic signed [TW-1:0]    t1, ax1, ay1;
  logic signed [CTR_W-1:0] cx1, cy1;
  // Stage 2: denominator and clamp, numerators times the scale.
  logic                    v2, cl2;
  logic signed [DW-1:0]    d_raw, d2;
  logic signed [PW-1:0]    nx2, ny2;
  logic signed [CTR_W-1:0] cx2, cy2;
  // Stage 3: magnitudes with half the divisor added.
  pside_t                  s3;
  logic [NW-1:0]           numx3, numy3;
  logic [DEN_W-1:0]        den3;
  logic [PW-2:0]           magx, magy;
  pside_t                  sv_q [0:QW-1];
  logic [QW-1:0]           qx, qy;
  logic signed [QW:0]      vx, vy;
  logic signed [SUM_W-1:0] sumx, sumy;

  always_ff @(posedge clk) begin
    t1  <= z2 * $signed({1'b0, size});
    ax1 <= x3 * $signed({1'b0, size});
    ay1 <= y3 * $signed({1'b0, size});
    cx1 <= cx;
    cy1 <= cy;
  end

  assign d_raw = PERSP_M + DW'(t1);

  always_ff @(posedge clk) begin
    if (d_raw <= PERSP_DMIN) begin
      d2  <= PERSP_DMIN;
      cl2 <= 1'b1;
    end else begin
      d2  <= d_raw;
      cl2 <= 1'b0;
    end
    nx2 <= ax1 * PERSP_SCALE;
    ny2 <= ay1 * PERSP_SCALE;
    cx2 <= cx1;
    cy2 <= cy1;
  end

  assign magx = nx2[PW-1] ? (PW-1)'(-nx2) : (PW-1)'(nx2);
  assign magy = ny2[PW-1] ? (PW-1)'(-ny2) : (PW-1)'(ny2);

  always_ff @(posedge clk) begin
    numx3      <= NW'(magx) + NW'(d2[DEN_W-1:1]);
    numy3      <= NW'(magy) + NW'(d2[DEN_W-1:1]);
    den3       <= d2[DEN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      s3.v <= 1'b0;
    end else begin
      v1         <= in_valid;
      v2         <= v1;
      s3.v       <= v2;
      s3.neg_x   <= nx2[PW-1];
      s3.neg_y   <= ny2[PW-1];
      s3.clamped <= cl2;
      s3.cx      <= cx2;
      s3.cy      <= cy2;
    end
  end

  wvrp_div u_div_x (.clk(clk), .num(numx3), .den(den3), .quot(qx));
  wvrp_div u_div_y (.clk(clk), .num(numy3), .den(den3), .quot(qy));

  // Side data rides along the divider stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < QW; k++) sv_q[k].v <= 1'b0;
    end else begin
      sv_q[0] <= s3;
      for (int k = 1; k < QW; k++) sv_q[k] <= sv_q[k-1];
    end
  end

  assign vx   = sv_q[QW-1].neg_x ? -$signed({1'b0, qx}) : $signed({1'b0, qx});
  assign vy   = sv_q[QW-1].neg_y ? -$signed({1'b0, qy}) : $signed({1'b0, qy});
  assign sumx = SUM_W'(sv_q[QW-1].cx) + SUM_W'(vx);
  assign sumy = SUM_W'(sv_q[QW-1].cy) + SUM_W'(vy);

  always_ff @(posedge clk) begin
    screen_x      <= sat32(sumx);
    screen_y      <= sat32(sumy);
    depth_clamped <= sv_q[QW-1].clamped;
  end

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else done <= sv_q[QW-1].v;
  end

endmodule

[rtl/core/wireframe_vertex_rotate_project_core.sv]
// Top level of the wireframe vertex rotate and project core.
// A new vertex is taken in every clock cycle (busy stays low), and its projected point
// leaves on the result ports, marked by done for one cycle.
// The latency is set by the 32-stage sine and cosine pipelines, three two-stage
// rotations and the 34-stage perspective path built around a 30-stage divider.
// Results cannot be held off, so the receiver must take each one as it appears.
// Users write thickness via the register port with no items in flight; not enforced.
module wireframe_vertex_rotate_project_core import wvrp_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic signed [PT_W-1:0]  point_x,
  input  logic signed [PT_W-1:0]  point_y,
  input  logic signed [PT_W-1:0]  point_z,
  input  logic                    is_prism,
  input  logic [15:0]             angle_x,
  input  logic [15:0]             angle_y,
  input  logic [15:0]             angle_z,
  input  logic [SIZE_W-1:0]       shape_size,
  input  logic signed [CTR_W-1:0] center_x,
  input  logic signed [CTR_W-1:0] center_y,
  output logic                    done,
  output logic signed [CTR_W-1:0] screen_x,
  output logic signed [CTR_W-1:0] screen_y,
  output logic                    depth_clamped,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [ADDR_W-1:0]       paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  logic [TP_W-1:0]              thickness;
  logic signed [TH_PROD_W-1:0]  th_prod, th_prod_q;
  logic [TH_MAG_W-1:0]          th_mag;
  logic [TH_Q_W-1:0]            th_scaled_q;
  logic                         th_neg_q;
  logic signed [ZW-1:0]         th_quot, zt;
  side_t                        in_side;
  side_t                        side_z;
  side_t                        side_q [0:CORDIC_LAT-1];
  logic signed [SC_W-1:0]       sx, cxs, sy, cys, sz, czs;
  hold_t                        h0;
  hold_t                        h2_in;
  hold_t                        h3_in;
  hold_t                        h1 [0:1];
  hold_t                        h2 [0:1];
  hold_t                        h3 [0:1];
  logic signed [CW-1:0]         r1_o1, r1_o2, r2_o1, r2_o2, r3_o1, r3_o2;

  assign busy   = 1'b0;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) thickness <= THICK_RESET;
    else if (psel && penable && pwrite && paddr[2] == REG_THICKNESS)
      thickness <= pwdata[TP_W-1:0];
  end

  assign prdata = (paddr[2] == REG_THICKNESS) ? 32'(thickness) : 32'd0;

  // Prism depth: z * percent / 100, truncated toward zero.
  assign th_prod = point_z * $signed({1'b0, thickness});
  assign th_mag  = th_prod_q[TH_PROD_W-1] ? TH_MAG_W'(-th_prod_q) : TH_MAG_W'(th_prod_q);
  assign th_quot = ZW'(th_scaled_q >> TH_SHIFT);
  assign zt      = side_q[1].prism ? (th_neg_q ? -th_quot : th_quot) : side_q[1].z;

  always_ff @(posedge clk) begin
    th_prod_q   <= th_prod;
    th_scaled_q <= th_mag * THICK_RECIP;
    th_neg_q    <= th_prod_q[TH_PROD_W-1];
  end

  always_comb begin
    in_side.v     = start;
    in_side.x     = point_x;
    in_side.y     = point_y;
    in_side.z     = ZW'(point_z);
    in_side.prism = is_prism;
    in_side.size  = shape_size;
    in_side.cx    = center_x;
    in_side.cy    = center_y;
  end

  always_comb begin
    side_z   = side_q[1];
    side_z.z = zt;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < CORDIC_LAT; k++) side_q[k].v <= 1'b0;
    end else begin
      side_q[0] <= in_side;
      side_q[1] <= side_q[0];
      side_q[2] <= side_z;
      for (int k = 3; k < CORDIC_LAT; k++) side_q[k] <= side_q[k-1];
    end
  end

  wvrp_cordic u_cordic_x (.clk(clk), .angle(angle_x), .sin_val(sx), .cos_val(cxs));
  wvrp_cordic u_cordic_y (.clk(clk), .angle(angle_y), .sin_val(sy), .cos_val(cys));
  wvrp_cordic u_cordic_z (.clk(clk), .angle(angle_z), .sin_val(sz), .cos_val(czs));

  always_comb begin
    h0.v    = side_q[CORDIC_LAT-1].v;
    h0.u    = CW'(side_q[CORDIC_LAT-1].x);
    h0.size = side_q[CORDIC_LAT-1].size;
    h0.cx   = side_q[CORDIC_LAT-1].cx;
    h0.cy   = side_q[CORDIC_LAT-1].cy;
    h0.s1   = sy;
    h0.c1   = cys;
    h0.s2   = sz;
    h0.c2   = czs;
  end

  // About X: y1 = y*c - z*s, z1 = y*s + z*c.
  wvrp_rot u_rot_x (
    .clk(clk), .a(CW'(side_q[CORDIC_LAT-1].y)), .b(CW'(side_q[CORDIC_LAT-1].z)),
    .c(cxs), .s(sx), .out1(r1_o1), .out2(r1_o2)
  );

  // About Y: z2 = z1*c - x*s, x2 = z1*s + x*c.
  wvrp_rot u_rot_y (
    .clk(clk), .a(r1_o2), .b(h1[1].u), .c(h1[1].c1), .s(h1[1].s1),
    .out1(r2_o1), .out2(r2_o2)
  );

  // About Z: x3 = x2*c - y1*s, y3 = x2*s + y1*c.
  wvrp_rot u_rot_z (
    .clk(clk), .a(r2_o2), .b(h2[1].u), .c(h2[1].c2), .s(h2[1].s2),
    .out1(r3_o1), .out2(r3_o2)
  );

  always_comb begin
    h2_in   = h1[1];
    h2_in.u = r1_o1;
    h3_in   = h2[1];
    h3_in.u = r2_o1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      h1[0].v <= 1'b0;
      h1[1].v <= 1'b0;
      h2[0].v <= 1'b0;
      h2[1].v <= 1'b0;
      h3[0].v <= 1'b0;
      h3[1].v <= 1'b0;
    end else begin
      h1[0]   <= h0;
      h1[1]   <= h1[0];
      h2[0]   <= h2_in;
      h2[1]   <= h2[0];
      h3[0]   <= h3_in;
      h3[1]   <= h3[0];
    end
  end

  wvrp_proj u_proj (
    .clk(clk), .rst(rst), .in_valid(h3[1].v),
    .x3(r3_o1), .y3(r3_o2), .z2(h3[1].u), .size(h3[1].size),
    .cx(h3[1].cx), .cy(h3[1].cy),
    .done(done), .screen_x(screen_x), .screen_y(screen_y),
    .depth_clamped(depth_clamped)
  );

endmodule
